// File: rtl/pfa_pkg.sv
// shared types and constants of the page frame allocator
// used by pfa_cell and page_frame_allocator; depends on nothing else
package pfa_pkg;

  localparam int unsigned FRAME_COUNT_DEF     = 32;
  localparam int unsigned FRAME_SIZE_LOG2_DEF = 22;

  // directory geometry and entry layout
  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned DIR_IDX_W   = 10;
  localparam int unsigned ENTRY_W     = 13;
  localparam int unsigned FRM_W       = 10;
  localparam int unsigned RUN_W       = 11;

  localparam logic [DIR_IDX_W-1:0] KERNEL_ENTRY = 10'h300;
  localparam logic [ENTRY_W-1:0]   KERNEL_VALUE = 13'h0003;
  localparam logic [2:0]           E_FLAGS_USER = 3'b111;

  // request codes
  localparam logic [1:0] REQ_CHECK = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // token that walks the cell row, one cell a cycle
  typedef struct packed {
    logic             valid;
    logic [RUN_W-1:0] run;
    logic             hit;
    logic             found;
    logic [FRM_W-1:0] free_frame;
    logic             tgt_used;
  } token_t;

  // bitmap update broadcast to all cells
  typedef struct packed {
    logic             set_en;
    logic [FRM_W-1:0] set_frame;
    logic             clr_en;
    logic [FRM_W-1:0] clr_frame;
  } bm_wr_t;

endpackage

// File: rtl/pfa_cell.sv
// one frame of the bitmap: holds its used bit and passes the search token on
// depends on pfa_pkg
module pfa_cell import pfa_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  token_t           tok_i,
  input  logic [RUN_W-1:0] need_i,
  input  logic [FRM_W-1:0] tgt_i,
  input  bm_wr_t           wr_i,
  output token_t           tok_o
);

  localparam logic [FRM_W-1:0] MY_IDX = FRM_W'(IDX);

  logic   used_q;
  token_t tok_d, tok_q;
  logic [RUN_W-1:0] run_nx;

  always_comb begin
    run_nx = used_q ? '0 : tok_i.run + RUN_W'(1);
    tok_d = tok_i;
    tok_d.run = run_nx;
    tok_d.hit = tok_i.hit | (!used_q && (run_nx == need_i));
    if (!tok_i.found && !used_q) begin
      tok_d.found      = 1'b1;
      tok_d.free_frame = MY_IDX;
    end
    tok_d.tgt_used = tok_i.tgt_used | (used_q && (tgt_i == MY_IDX));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= (IDX == 0);
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.set_en && wr_i.set_frame == MY_IDX) begin
        used_q <= 1'b1;
      end else if (wr_i.clr_en && wr_i.clr_frame == MY_IDX) begin
        used_q <= 1'b0;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/page_frame_allocator.sv
// steps: accept, directory read, search token sweep, then update and result once
//   the result register is free; one request at a time, the next taken only in
//   ST_IDLE, the search token walking the row of bitmap cells one frame per cycle
// reset: frame 0 used, free count FRAME_COUNT - 1; then a clearing pass over all
//   DIR_ENTRIES (1024) entries writes the directory, no request taken meanwhile
// top level: page frame allocator, uses pfa_pkg and pfa_cell
module page_frame_allocator import pfa_pkg::*; #(
  parameter int unsigned FRAME_COUNT     = FRAME_COUNT_DEF,
  parameter int unsigned FRAME_SIZE_LOG2 = FRAME_SIZE_LOG2_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  dir_index_i,
  input  logic [31:0] amount_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [4:0]  frame_index_o,
  output logic [5:0]  free_frames_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_COUNT + 1);
  localparam logic [31:0] AMT_MASK = (32'd1 << FRAME_SIZE_LOG2) - 32'd1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_SWEEP, ST_UPD
  } state_e;

  state_e                state_q;
  logic [DIR_IDX_W-1:0]  clr_cnt_q;
  logic [1:0]            req_q;
  logic [DIR_IDX_W-1:0]  idx_q;
  logic [RUN_W-1:0]      need_q;
  logic                  need_ok_q;
  token_t                res_q;
  logic [CNT_W-1:0]      free_cnt_q, cnt_d;
  logic                  out_valid_q, ok_q;
  logic [4:0]            frm_q;
  logic [5:0]            free_q;

  // directory memory
  logic [ENTRY_W-1:0]    dir_mem [DIR_ENTRIES];
  logic [ENTRY_W-1:0]    rd_q;
  logic                  mem_we;
  logic [DIR_IDX_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0]    mem_wd;

  logic                  accept;
  logic                  upd_go;
  logic [32:0]           need_w;
  logic                  ent_present;
  logic [FRM_W-1:0]      ent_frame;

  logic                  ok_d, dir_we;
  logic [FRM_W-1:0]      frm_d;
  logic [ENTRY_W-1:0]    dir_wd;
  bm_wr_t                bm_wr, bm_wr_g;
  logic [31:0]           cnt_ext;

  token_t                tok_w [FRAME_COUNT+1];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  // frames needed, rounded up
  assign need_w = 33'(amount_bytes_i >> FRAME_SIZE_LOG2)
                + 33'((amount_bytes_i & AMT_MASK) != 32'd0);

  assign ent_present = rd_q[0];
  assign ent_frame   = rd_q[ENTRY_W-1:3];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dir_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= dir_mem[dir_index_i];
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = (clr_cnt_q == KERNEL_ENTRY) ? KERNEL_VALUE : '0;
    end else begin
      mem_we = upd_go && dir_we;
      mem_wa = idx_q;
      mem_wd = dir_wd;
    end
  end

  // request outcome, applied when the result register is free
  always_comb begin
    ok_d   = 1'b0;
    frm_d  = '0;
    cnt_d  = free_cnt_q;
    bm_wr  = '0;
    dir_we = 1'b0;
    dir_wd = '0;
    unique case (req_q)
      REQ_CHECK: begin
        ok_d = need_ok_q && res_q.hit;
      end
      REQ_ALLOC: begin
        if (res_q.found) begin
          ok_d            = 1'b1;
          frm_d           = res_q.free_frame;
          bm_wr.set_en    = 1'b1;
          bm_wr.set_frame = res_q.free_frame;
          if (free_cnt_q != '0) begin
            cnt_d = free_cnt_q - CNT_W'(1);
          end
          dir_we = 1'b1;
          dir_wd = {res_q.free_frame, E_FLAGS_USER};
        end
      end
      REQ_FREE: begin
        if (ent_present) begin
          ok_d  = 1'b1;
          frm_d = ent_frame;
          // a frame already free keeps the count as it is
          if (res_q.tgt_used) begin
            bm_wr.clr_en    = 1'b1;
            bm_wr.clr_frame = ent_frame;
            cnt_d           = free_cnt_q + CNT_W'(1);
          end
          dir_we = 1'b1;
          dir_wd = '0;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign bm_wr_g = upd_go ? bm_wr : '0;
  assign cnt_ext = 32'(cnt_d);

  // search token enters the row while the directory entry is on hand
  assign tok_w[0] = token_t'({(state_q == ST_RD), ($bits(token_t)-1)'(0)});

  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    pfa_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[g]),
      .need_i (need_q),
      .tgt_i  (ent_frame),
      .wr_i   (bm_wr_g),
      .tok_o  (tok_w[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      req_q       <= REQ_CHECK;
      idx_q       <= '0;
      need_q      <= '0;
      need_ok_q   <= 1'b0;
      res_q       <= '0;
      free_cnt_q  <= CNT_W'(FRAME_COUNT - 1);
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      frm_q       <= '0;
      free_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !upd_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + DIR_IDX_W'(1);
          if (clr_cnt_q == DIR_IDX_W'(DIR_ENTRIES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_q     <= req_type_i;
            idx_q     <= dir_index_i;
            need_q    <= need_w[RUN_W-1:0];
            need_ok_q <= (need_w != 33'd0) && (need_w <= 33'(FRAME_COUNT));
            state_q   <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (tok_w[FRAME_COUNT].valid) begin
            res_q   <= tok_w[FRAME_COUNT];
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            out_valid_q <= 1'b1;
            ok_q        <= ok_d;
            frm_q       <= frm_d[4:0];
            free_q      <= cnt_ext[5:0];
            free_cnt_q  <= cnt_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign frame_index_o = frm_q;
  assign free_frames_o = free_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CNT_W'(FRAME_COUNT))
    else $error("free frame count above frame count");

  a_tok_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_w[FRAME_COUNT].valid |-> (state_q == ST_SWEEP))
    else $error("search token left the row outside a sweep");

  a_fail_frame0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (frame_index_o == 5'd0))
    else $error("failed request reports a frame");

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && req_q == REQ_ALLOC && res_q.found) |=>
      (free_cnt_q == $past(free_cnt_q) - CNT_W'(1)))
    else $error("allocate did not take a frame from the count");

  a_accept_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RD))
    else $error("accepted request did not start a directory read");

endmodule

// File: verif/tb_page_frame_allocator.sv
// self-checking testbench for page_frame_allocator: directed table, then random requests
// checks typed rows against the table, others against a model of bitmap and directory
// depends on rtl/pfa_pkg.sv and rtl/page_frame_allocator.sv
`timescale 1ns / 100ps

module tb_page_frame_allocator;
  import pfa_pkg::*;

  localparam int unsigned FRAME_COUNT     = FRAME_COUNT_DEF;
  localparam int unsigned FRAME_SIZE_LOG2 = FRAME_SIZE_LOG2_DEF;
  localparam int unsigned RANDOM_REQS     = 2000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned POOL_SIZE       = 40;
  localparam logic [1:0]  REQ_BAD         = 2'd3;
  localparam logic        TYPED           = 1'b1;
  localparam logic        PREDICTED       = 1'b0;

  typedef struct packed {
    logic       ok;
    logic [4:0] frame;
    logic [5:0] free;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  idx;
    logic [31:0] amt;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam result_t NO_WANT = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [9:0]  dir_index_i;
  logic [31:0] amount_bytes_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        ok_o;
  logic [4:0]  frame_index_o;
  logic [5:0]  free_frames_o;

  // model of the allocator state
  logic [FRAME_COUNT-1:0] frame_busy;
  int unsigned            free_total;
  logic [ENTRY_W-1:0]     dir_shadow [DIR_ENTRIES];

  result_t     pending_results [$];
  logic        row_typed;
  result_t     row_want;
  logic        hold_off_req;
  logic        hold_off_done;
  logic [9:0]  idx_pool [POOL_SIZE];

  int unsigned check_cnt, alloc_cnt, alloc_refused, free_cnt, free_missed, bad_cnt;
  int unsigned results_seen, mismatches;

  // frame-boundary checks first, then mapping corner cases from the reset state
  dir_row_t directed_rows [0:20] = '{
    '{REQ_CHECK, 10'h000, 32'h0000_0000, TYPED, '{1'b0, 5'd0, 6'd31}},
    '{REQ_CHECK, 10'h000, 32'hFFFF_FFFF, TYPED, '{1'b0, 5'd0, 6'd31}},
    '{REQ_CHECK, 10'h000, 32'h0000_0001, TYPED, '{1'b1, 5'd0, 6'd31}},
    '{REQ_CHECK, 10'h000, 32'h07C0_0000, TYPED, '{1'b1, 5'd0, 6'd31}},
    '{REQ_CHECK, 10'h000, 32'h07C0_0001, TYPED, '{1'b0, 5'd0, 6'd31}},
    '{REQ_CHECK, 10'h000, 32'h8000_0001, TYPED, '{1'b0, 5'd0, 6'd31}},
    '{REQ_BAD,   10'h3FF, 32'hFFFF_FFFF, TYPED, '{1'b0, 5'd0, 6'd31}},
    '{REQ_FREE,  10'h000, 32'h0000_0000, TYPED, '{1'b0, 5'd0, 6'd31}},
    '{REQ_ALLOC, 10'h000, 32'h0000_0000, TYPED, '{1'b1, 5'd1, 6'd30}},
    '{REQ_ALLOC, 10'h3FF, 32'hFFFF_FFFF, PREDICTED, NO_WANT},
    '{REQ_ALLOC, 10'h000, 32'h5555_5555, PREDICTED, NO_WANT},
    '{REQ_FREE,  10'h000, 32'hAAAA_AAAA, PREDICTED, NO_WANT},
    '{REQ_CHECK, 10'h155, 32'h4000_0000, PREDICTED, NO_WANT},
    '{REQ_FREE,  KERNEL_ENTRY, 32'h0000_0000, PREDICTED, NO_WANT},
    '{REQ_ALLOC, KERNEL_ENTRY, 32'h0000_0000, PREDICTED, NO_WANT},
    '{REQ_ALLOC, 10'h155, 32'h0000_0000, PREDICTED, NO_WANT},
    '{REQ_FREE,  10'h3FF, 32'h0000_0000, PREDICTED, NO_WANT},
    '{REQ_FREE,  10'h3FF, 32'h0000_0000, PREDICTED, NO_WANT},
    '{REQ_CHECK, 10'h2AA, 32'h0040_0000, PREDICTED, NO_WANT},
    '{REQ_CHECK, 10'h2AA, 32'h003F_FFFF, PREDICTED, NO_WANT},
    '{REQ_ALLOC, 10'h2AA, 32'hAAAA_AAAA, PREDICTED, NO_WANT}
  };

  page_frame_allocator #(
    .FRAME_COUNT    (FRAME_COUNT),
    .FRAME_SIZE_LOG2(FRAME_SIZE_LOG2)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .dir_index_i   (dir_index_i),
    .amount_bytes_i(amount_bytes_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .frame_index_o (frame_index_o),
    .free_frames_o (free_frames_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("page_frame_allocator test failed");
    $finish;
  end

  // true when ceil(amt / frame size) is nonzero and a contiguous run of that many free frames exists
  function automatic logic run_fits(input logic [31:0] amt);
    longint unsigned need;
    int unsigned     streak;
    logic            hit;
    need   = ({32'd0, amt} + (64'd1 << FRAME_SIZE_LOG2) - 64'd1) >> FRAME_SIZE_LOG2;
    streak = 0;
    hit    = 1'b0;
    if (need != 0 && need <= FRAME_COUNT) begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        if (frame_busy[i]) begin
          streak = 0;
        end else begin
          streak++;
          if (streak == need) hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic result_t apply_request(input logic [1:0] kind, input logic [9:0] idx,
                                            input logic [31:0] amt);
    result_t          r;
    int unsigned      slot;
    logic [FRM_W-1:0] held;
    r = '0;
    case (kind)
      REQ_CHECK: begin
        check_cnt++;
        r.ok = run_fits(amt);
      end
      REQ_ALLOC: begin
        alloc_cnt++;
        slot = FRAME_COUNT;
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
          if (!frame_busy[i]) slot = i;
        end
        if (slot < FRAME_COUNT) begin
          frame_busy[slot] = 1'b1;
          if (free_total != 0) free_total--;
          // overwriting a mapped entry leaves its old frame marked used
          dir_shadow[idx] = {slot[FRM_W-1:0], E_FLAGS_USER};
          r.ok    = 1'b1;
          r.frame = slot[4:0];
        end else begin
          alloc_refused++;
        end
      end
      REQ_FREE: begin
        free_cnt++;
        if (dir_shadow[idx][0]) begin
          held = dir_shadow[idx][ENTRY_W-1:3];
          if (held < FRAME_COUNT && frame_busy[held]) begin
            frame_busy[held] = 1'b0;
            free_total++;
          end
          dir_shadow[idx] = '0;
          r.ok    = 1'b1;
          r.frame = held[4:0];
        end else begin
          free_missed++;
        end
      end
      default: begin
        bad_cnt++;
      end
    endcase
    r.free = free_total[5:0];
    return r;
  endfunction

  function automatic int unsigned idle_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  initial begin
    frame_busy    = '0;
    frame_busy[0] = 1'b1;
    free_total    = FRAME_COUNT - 1;
    for (int i = 0; i < DIR_ENTRIES; i++) dir_shadow[i] = '0;
    dir_shadow[KERNEL_ENTRY] = KERNEL_VALUE;
  end

  // checks results against the oldest expectation, then predicts each accepted request
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: ok %0d frame %0d free %0d",
               ok_o, frame_index_o, free_frames_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok_o);
          mismatches++;
        end
        if (frame_index_o !== want.frame) begin
          $error("frame_index: expected %0d, got %0d", want.frame, frame_index_o);
          mismatches++;
        end
        if (free_frames_o !== want.free) begin
          $error("free_frames: expected %0d, got %0d", want.free, free_frames_o);
          mismatches++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      want = apply_request(req_type_i, dir_index_i, amount_bytes_i);
      pending_results.push_back(row_typed ? row_want : want);
    end
  end

  // result side: mostly ready, random stalls, one long hold-off to back up the block
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_done = 1'b1;
      end
      out_ready_i = 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 12))
        @(negedge clk_i);
      stall = idle_gap(1'b0);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // offers one request at a falling edge and returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] kind, input logic [9:0] idx,
                              input logic [31:0] amt, input logic typed, input result_t want,
                              input bit calm);
    int unsigned gap;
    gap = (hold_off_req && !hold_off_done) ? 0 : idle_gap(calm);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i     = kind;
    dir_index_i    = idx;
    amount_bytes_i = amt;
    row_typed      = typed;
    row_want       = want;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pct_alloc, pct_free, r, n;
    bit          calm;
    logic [1:0]  kind;
    logic [9:0]  idx;
    logic [31:0] amt;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_CHECK;
    dir_index_i    = '0;
    amount_bytes_i = '0;
    row_typed      = PREDICTED;
    row_want       = NO_WANT;
    hold_off_req   = 1'b0;
    hold_off_done  = 1'b0;
    pct_alloc      = 35;
    pct_free       = 35;
    calm           = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) idx_pool[i] = 10'($urandom);
    idx_pool[0] = 10'h000;
    idx_pool[1] = 10'h3FF;
    idx_pool[2] = KERNEL_ENTRY;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].amt,
                   directed_rows[i].typed, directed_rows[i].want, 1'b0);

    hold_off_req = 1'b1;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      // phases that fill the bitmap, drain it, or mix
      if (k % 120 == 0) begin
        case ($urandom_range(0, 2))
          0: begin pct_alloc = 65; pct_free = 15; end
          1: begin pct_alloc = 15; pct_free = 65; end
          default: begin pct_alloc = 35; pct_free = 35; end
        endcase
        calm = ($urandom_range(0, 3) == 0);
      end
      r   = $urandom_range(0, 99);
      amt = $urandom;
      idx = idx_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < pct_alloc) begin
        kind = REQ_ALLOC;
        // aim at unmapped entries; overwriting one leaks its frame for good
        if ($urandom_range(0, 199) != 0) begin
          for (int t = 0; t < 16 && dir_shadow[idx][0]; t++)
            idx = idx_pool[$urandom_range(0, POOL_SIZE - 1)];
          if (dir_shadow[idx][0]) idx = 10'($urandom);
        end
      end else if (r < pct_alloc + pct_free) begin
        kind = REQ_FREE;
        if ($urandom_range(0, 99) < 85) begin
          for (int t = 0; t < 16 && !dir_shadow[idx][0]; t++)
            idx = idx_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          idx = 10'($urandom);
        end
      end else if (r < 98) begin
        kind = REQ_CHECK;
        case ($urandom_range(0, 4))
          0: amt = $urandom;
          1: begin
            n   = $urandom_range(1, 33);
            amt = (32'(n) << FRAME_SIZE_LOG2) - 32'($urandom_range(0, (1 << FRAME_SIZE_LOG2) - 1));
          end
          2: begin
            n   = $urandom_range(1, 32);
            amt = (32'(n) << FRAME_SIZE_LOG2) + 32'($urandom_range(0, 1));
          end
          3: amt = 32'($urandom_range(1, 1 << FRAME_SIZE_LOG2));
          default: amt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
      end else begin
        kind = REQ_BAD;
      end
      send_request(kind, idx, amt, PREDICTED, NO_WANT, calm);
    end
    in_valid_i = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (FRAME_COUNT + 8) @(posedge clk_i);

    $display("covered %0d checks, %0d allocations (%0d refused on a full bitmap),",
             check_cnt, alloc_cnt, alloc_refused);
    $display("%0d frees (%0d of unmapped entries), %0d bad codes; %0d results, %0d mismatches",
             free_cnt, free_missed, bad_cnt, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("page_frame_allocator test passed");
    end else begin
      $display("page_frame_allocator test failed");
    end
    $finish;
  end

endmodule
